// ===== hdl/rj_pkg.sv =====
// rj_pkg: shared types and constants for the radar Jacobian unit.
// No dependencies.
`timescale 1ns / 1ps
package rj_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned WIDE_W  = 64;
    localparam int unsigned DEN_W   = 96;
    localparam int unsigned NUM_W   = 128;
    localparam int unsigned N_TERMS = 6;
    localparam int unsigned Q_DEPTH = 2;

    typedef struct packed {
        logic [DATA_W-1:0] pm;
        logic [DATA_W-1:0] qm;
        logic [DATA_W-1:0] vxm;
        logic [DATA_W-1:0] vym;
        logic              p_neg;
        logic              q_neg;
        logic              vx_neg;
        logic              vy_neg;
        logic              zero;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_PROD,
        ST_DLOAD,
        ST_DITER,
        ST_DPACK,
        ST_EMIT
    } back_state_t;

    localparam logic [2:0] TERM_RHO_X  = 3'd0;
    localparam logic [2:0] TERM_RHO_Y  = 3'd1;
    localparam logic [2:0] TERM_PHI_X  = 3'd2;
    localparam logic [2:0] TERM_PHI_Y  = 3'd3;
    localparam logic [2:0] TERM_RATE_X = 3'd4;
    localparam logic [2:0] TERM_RATE_Y = 3'd5;

endpackage

// ===== hdl/rj_front.sv =====
// rj_front: takes a state vector apart into signs and magnitudes and flags zero range.
// Depends on rj_pkg.
`timescale 1ns / 1ps
module rj_front
(
    input  logic signed [rj_pkg::DATA_W-1:0] pos_x,
    input  logic signed [rj_pkg::DATA_W-1:0] pos_y,
    input  logic signed [rj_pkg::DATA_W-1:0] vel_x,
    input  logic signed [rj_pkg::DATA_W-1:0] vel_y,
    output rj_pkg::item_t                    item
);

    function automatic logic [rj_pkg::DATA_W-1:0] mag(input logic [rj_pkg::DATA_W-1:0] v);
        mag = v[rj_pkg::DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb
    begin
        item.pm     = mag(pos_x);
        item.qm     = mag(pos_y);
        item.vxm    = mag(vel_x);
        item.vym    = mag(vel_y);
        item.p_neg  = pos_x[rj_pkg::DATA_W-1];
        item.q_neg  = pos_y[rj_pkg::DATA_W-1];
        item.vx_neg = vel_x[rj_pkg::DATA_W-1];
        item.vy_neg = vel_y[rj_pkg::DATA_W-1];
        item.zero   = (pos_x == '0) && (pos_y == '0);
    end

endmodule

// ===== hdl/rj_queue.sv =====
// rj_queue: two-entry queue between the front and back parts.
// Depends on rj_pkg.
`timescale 1ns / 1ps
module rj_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rj_pkg::item_t push_item,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output rj_pkg::item_t head
);

    rj_pkg::item_t mem [rj_pkg::Q_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign full  = (count_reg == 2'(rj_pkg::Q_DEPTH));
    assign valid = (count_reg != 2'd0);
    assign head  = mem[rd_ptr_reg];

endmodule

// ===== hdl/rj_back.sv =====
// rj_back: sequencer with one 32x32 multiplier, a bit-serial square root and a
// restoring divider that works out the six Jacobian terms. Depends on rj_pkg.
`timescale 1ns / 1ps
module rj_back
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  rj_pkg::item_t                    q_head,
    output logic                             q_pop,
    output logic                             done,
    output logic signed [rj_pkg::DATA_W-1:0] drho_dpx,
    output logic signed [rj_pkg::DATA_W-1:0] drho_dpy,
    output logic signed [rj_pkg::DATA_W-1:0] dphi_dpx,
    output logic signed [rj_pkg::DATA_W-1:0] dphi_dpy,
    output logic signed [rj_pkg::DATA_W-1:0] drate_dpx,
    output logic signed [rj_pkg::DATA_W-1:0] drate_dpy,
    output logic                             zero_range,
    output logic                             saturated
);

    localparam int unsigned DW = rj_pkg::DATA_W;
    localparam int unsigned WW = rj_pkg::WIDE_W;
    localparam int unsigned EW = rj_pkg::DEN_W;
    localparam int unsigned NW = rj_pkg::NUM_W;

    rj_pkg::back_state_t state_reg, state_next;
    rj_pkg::item_t       cur_reg;
    logic [4:0]          cnt_reg;
    logic [2:0]          k_reg;

    logic [WW-1:0] r2_reg, a_reg, b_reg, cm_reg;
    logic          cneg_reg;
    logic [WW-1:0] v_reg, root_reg, bit_reg;
    logic [EW-1:0] dc_reg, nqc_reg, npc_reg;
    logic [EW-1:0] rem_reg;
    logic [DW-1:0] nlo_reg, quo_reg;
    logic          ovf_reg;
    logic [DW-1:0] res_reg [rj_pkg::N_TERMS];
    logic          zr_reg, sat_reg;

    logic [DW-1:0] mul_a, mul_b;
    logic [WW-1:0] prod;
    logic [NW-1:0] num_sel;
    logic [EW-1:0] den_sel;
    logic          neg_sel;
    logic          ovf;
    logic [WW-1:0] sq_sum;
    logic [EW:0]   rem2;
    logic [DW-1:0] lim, pack_m;
    logic          pack_sat;
    logic          a_neg, nb_neg;

    // multiplier operand select
    always_comb
    begin
        mul_a = cur_reg.pm;
        mul_b = cur_reg.pm;
        if (state_reg == rj_pkg::ST_MUL)
        begin
            case (cnt_reg)
                5'd1:    begin mul_a = cur_reg.qm;  mul_b = cur_reg.qm; end
                5'd2:    begin mul_a = cur_reg.vxm; mul_b = cur_reg.qm; end
                5'd3:    begin mul_a = cur_reg.vym; mul_b = cur_reg.pm; end
                default: begin mul_a = cur_reg.pm;  mul_b = cur_reg.pm; end
            endcase
        end
        else
        begin
            case (cnt_reg)
                5'd0:    begin mul_a = root_reg[DW-1:0]; mul_b = r2_reg[DW-1:0];  end
                5'd1:    begin mul_a = root_reg[DW-1:0]; mul_b = r2_reg[WW-1:DW]; end
                5'd2:    begin mul_a = cur_reg.qm;       mul_b = cm_reg[DW-1:0];  end
                5'd3:    begin mul_a = cur_reg.qm;       mul_b = cm_reg[WW-1:DW]; end
                5'd4:    begin mul_a = cur_reg.pm;       mul_b = cm_reg[DW-1:0];  end
                default: begin mul_a = cur_reg.pm;       mul_b = cm_reg[WW-1:DW]; end
            endcase
        end
    end

    assign prod = WW'(mul_a) * WW'(mul_b);

    // divider operand select
    always_comb
    begin
        case (k_reg)
            rj_pkg::TERM_RHO_X:
            begin
                num_sel = NW'(cur_reg.pm) << FRAC_BITS;
                den_sel = EW'(root_reg[DW-1:0]);
                neg_sel = cur_reg.p_neg;
            end
            rj_pkg::TERM_RHO_Y:
            begin
                num_sel = NW'(cur_reg.qm) << FRAC_BITS;
                den_sel = EW'(root_reg[DW-1:0]);
                neg_sel = cur_reg.q_neg;
            end
            rj_pkg::TERM_PHI_X:
            begin
                num_sel = NW'(cur_reg.qm) << (2 * FRAC_BITS);
                den_sel = EW'(r2_reg);
                neg_sel = !cur_reg.q_neg && (cur_reg.qm != '0);
            end
            rj_pkg::TERM_PHI_Y:
            begin
                num_sel = NW'(cur_reg.pm) << (2 * FRAC_BITS);
                den_sel = EW'(r2_reg);
                neg_sel = cur_reg.p_neg;
            end
            rj_pkg::TERM_RATE_X:
            begin
                num_sel = NW'(nqc_reg) << FRAC_BITS;
                den_sel = dc_reg;
                neg_sel = cur_reg.q_neg != cneg_reg;
            end
            default:
            begin
                num_sel = NW'(npc_reg) << FRAC_BITS;
                den_sel = dc_reg;
                neg_sel = (cur_reg.p_neg == cneg_reg) && (cur_reg.pm != '0)
                          && (cm_reg != '0);
            end
        endcase
    end

    assign ovf    = num_sel >= {den_sel, {DW{1'b0}}};
    assign sq_sum = root_reg + bit_reg;
    assign rem2   = {rem_reg, nlo_reg[DW-1]};

    assign lim      = neg_sel ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    assign pack_sat = ovf_reg || (quo_reg > lim);
    assign pack_m   = pack_sat ? lim : quo_reg;

    assign a_neg  = (cur_reg.vx_neg ^ cur_reg.q_neg) && (a_reg != '0);
    assign nb_neg = !(cur_reg.vy_neg ^ cur_reg.p_neg) && (b_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rj_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_head.zero ? rj_pkg::ST_EMIT : rj_pkg::ST_MUL;
                end
            end
            rj_pkg::ST_MUL:
            begin
                if (cnt_reg == 5'd4)
                begin
                    state_next = rj_pkg::ST_SQRT;
                end
            end
            rj_pkg::ST_SQRT:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = rj_pkg::ST_PROD;
                end
            end
            rj_pkg::ST_PROD:
            begin
                if (cnt_reg == 5'd5)
                begin
                    state_next = rj_pkg::ST_DLOAD;
                end
            end
            rj_pkg::ST_DLOAD:
            begin
                state_next = ovf ? rj_pkg::ST_DPACK : rj_pkg::ST_DITER;
            end
            rj_pkg::ST_DITER:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = rj_pkg::ST_DPACK;
                end
            end
            rj_pkg::ST_DPACK:
            begin
                state_next = (k_reg == rj_pkg::TERM_RATE_Y) ? rj_pkg::ST_EMIT
                                                            : rj_pkg::ST_DLOAD;
            end
            rj_pkg::ST_EMIT:
            begin
                state_next = rj_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rj_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == rj_pkg::ST_IDLE) && q_valid;
        done  = (state_reg == rj_pkg::ST_EMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rj_pkg::ST_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 5'd0 : cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            rj_pkg::ST_IDLE:
            begin
                cur_reg <= q_head;
                k_reg   <= rj_pkg::TERM_RHO_X;
                sat_reg <= 1'b0;
                zr_reg  <= q_head.zero;
                if (q_head.zero)
                begin
                    for (int i = 0; i < rj_pkg::N_TERMS; i++)
                    begin
                        res_reg[i] <= '0;
                    end
                end
            end
            rj_pkg::ST_MUL:
            begin
                case (cnt_reg)
                    5'd0: r2_reg <= prod;
                    5'd1: r2_reg <= r2_reg + prod;
                    5'd2: a_reg  <= prod;
                    5'd3: b_reg  <= prod;
                    default:
                    begin
                        if (a_neg == nb_neg)
                        begin
                            cm_reg   <= a_reg + b_reg;
                            cneg_reg <= a_neg;
                        end
                        else if (a_reg >= b_reg)
                        begin
                            cm_reg   <= a_reg - b_reg;
                            cneg_reg <= a_neg && (a_reg != b_reg);
                        end
                        else
                        begin
                            cm_reg   <= b_reg - a_reg;
                            cneg_reg <= nb_neg;
                        end
                        v_reg    <= r2_reg;
                        root_reg <= '0;
                        bit_reg  <= WW'(1) << (WW - 2);
                    end
                endcase
            end
            rj_pkg::ST_SQRT:
            begin
                if (v_reg >= sq_sum)
                begin
                    v_reg    <= v_reg - sq_sum;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            rj_pkg::ST_PROD:
            begin
                case (cnt_reg)
                    5'd0:    dc_reg  <= EW'(prod);
                    5'd1:    dc_reg  <= dc_reg + {prod, {DW{1'b0}}};
                    5'd2:    nqc_reg <= EW'(prod);
                    5'd3:    nqc_reg <= nqc_reg + {prod, {DW{1'b0}}};
                    5'd4:    npc_reg <= EW'(prod);
                    default: npc_reg <= npc_reg + {prod, {DW{1'b0}}};
                endcase
            end
            rj_pkg::ST_DLOAD:
            begin
                ovf_reg <= ovf;
                rem_reg <= num_sel[NW-1:DW];
                nlo_reg <= num_sel[DW-1:0];
                quo_reg <= '0;
            end
            rj_pkg::ST_DITER:
            begin
                if (rem2 >= {1'b0, den_sel})
                begin
                    rem_reg <= EW'(rem2 - {1'b0, den_sel});
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[EW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
                nlo_reg <= {nlo_reg[DW-2:0], 1'b0};
            end
            rj_pkg::ST_DPACK:
            begin
                res_reg[k_reg] <= neg_sel ? (~pack_m + 1'b1) : pack_m;
                sat_reg        <= sat_reg | pack_sat;
                k_reg          <= k_reg + 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign drho_dpx   = res_reg[rj_pkg::TERM_RHO_X];
    assign drho_dpy   = res_reg[rj_pkg::TERM_RHO_Y];
    assign dphi_dpx   = res_reg[rj_pkg::TERM_PHI_X];
    assign dphi_dpy   = res_reg[rj_pkg::TERM_PHI_Y];
    assign drate_dpx  = res_reg[rj_pkg::TERM_RATE_X];
    assign drate_dpy  = res_reg[rj_pkg::TERM_RATE_Y];
    assign zero_range = zr_reg;
    assign saturated  = sat_reg;

endmodule

// ===== hdl/radar_jacobian_unit.sv =====
// radar_jacobian_unit: top level of the radar measurement Jacobian block.
// Depends on rj_pkg, rj_front, rj_queue, rj_back.
//
// Usage: drive pos_x, pos_y, vel_x, vel_y (signed, FRAC_BITS fraction bits)
// and raise start. A beat is taken on a rising edge with start high and busy
// low. busy is high only while the two-entry input queue is full.
// Each beat gives one result beat: done is high for exactly one cycle and the
// six Jacobian terms, zero_range and saturated are valid in that cycle. The
// receiver cannot stall, so done is never held off.
// Sequence: one item at a time in the back part: a pop, the multiplies,
// 32 square-root steps and the products, then per term a load, 32 divide
// steps and a pack, then the done state; a term whose quotient overflows
// skips its divide steps, and a zero-range item goes from the pop straight
// to done. Up to two further items wait in the queue.
// Reset empties the queue and returns the sequencer to idle.
`timescale 1ns / 1ps
module radar_jacobian_unit
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [rj_pkg::DATA_W-1:0] pos_x,
    input  logic signed [rj_pkg::DATA_W-1:0] pos_y,
    input  logic signed [rj_pkg::DATA_W-1:0] vel_x,
    input  logic signed [rj_pkg::DATA_W-1:0] vel_y,
    output logic                             done,
    output logic signed [rj_pkg::DATA_W-1:0] drho_dpx,
    output logic signed [rj_pkg::DATA_W-1:0] drho_dpy,
    output logic signed [rj_pkg::DATA_W-1:0] dphi_dpx,
    output logic signed [rj_pkg::DATA_W-1:0] dphi_dpy,
    output logic signed [rj_pkg::DATA_W-1:0] drate_dpx,
    output logic signed [rj_pkg::DATA_W-1:0] drate_dpy,
    output logic                             zero_range,
    output logic                             saturated
);

    rj_pkg::item_t front_item;
    rj_pkg::item_t q_head;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;

    rj_front u_front
    (
        .pos_x (pos_x),
        .pos_y (pos_y),
        .vel_x (vel_x),
        .vel_y (vel_y),
        .item  (front_item)
    );

    rj_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start && !q_full),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    rj_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .done       (done),
        .drho_dpx   (drho_dpx),
        .drho_dpy   (drho_dpy),
        .dphi_dpx   (dphi_dpx),
        .dphi_dpy   (dphi_dpy),
        .drate_dpx  (drate_dpx),
        .drate_dpy  (drate_dpy),
        .zero_range (zero_range),
        .saturated  (saturated)
    );

    assign busy = q_full;

endmodule
